@@ rtl/core/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REVERSE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
        logic respond;
    } ctrl_t;

endpackage

@@ rtl/core/deq_ctrl.sv @@
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_READ;
            S_READ:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        ctrl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            S_EXEC:  ctrl.exec    = 1'b1;
            S_READ:  ctrl.read    = 1'b1;
            S_RESP:  ctrl.respond = 1'b1;
            default: busy         = 1'b1;
        endcase
    end

endmodule

@@ rtl/core/deq_datapath.sv @@
`timescale 1ns / 1ps

module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 ctrl,
    input  logic [2:0]            command,
    input  logic [VALUE_BITS-1:0] value,
    output logic [VALUE_BITS-1:0] front_value,
    output logic [VALUE_BITS-1:0] back_value,
    output logic [CW-1:0]         entry_count,
    output logic                  is_empty,
    output logic [1:0]            status
);

    localparam int SW = CW + 1;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic [2:0]            cmd_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rev_reg;
    logic                  rev_next;
    status_t               status_reg;
    status_t               status_next;
    logic [VALUE_BITS-1:0] rd_lo_reg;
    logic [VALUE_BITS-1:0] rd_hi_reg;

    logic                  full;
    logic                  empty;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [SW-1:0]         tail_sum;
    logic [AW-1:0]         tail_idx;
    logic [SW-1:0]         high_sum;
    logic [AW-1:0]         high_idx;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Both sums stay below twice the depth, so one subtraction wraps them.
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign high_sum = tail_sum - SW'(1);
    assign high_idx = (high_sum >= SW'(DEPTH)) ? AW'(high_sum - SW'(DEPTH)) : AW'(high_sum);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = ST_DONE;
        mem_we      = 1'b0;
        mem_waddr   = tail_idx;
        unique case (cmd_reg)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    // The low physical end is the front unless the order is reversed.
                    if ((cmd_reg == CMD_PUSH_FRONT) != rev_reg)
                    begin
                        head_next = head_dec;
                        mem_waddr = head_dec;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if ((cmd_reg == CMD_POP_FRONT) != rev_reg)
                    begin
                        head_next = head_inc;
                    end
                end
            end
            CMD_REVERSE:
            begin
                if (count_reg > CW'(1))
                begin
                    rev_next = !rev_reg;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
        if (ctrl.exec && mem_we)
        begin
            mem[mem_waddr] <= value_reg;
        end
        if (ctrl.read)
        begin
            rd_lo_reg <= mem[head_reg];
            rd_hi_reg <= mem[high_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= ST_DONE;
        end
        else if (ctrl.exec)
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
        end
    end

    assign front_value = empty ? '0 : (rev_reg ? rd_hi_reg : rd_lo_reg);
    assign back_value  = empty ? '0 : (rev_reg ? rd_lo_reg : rd_hi_reg);
    assign entry_count = count_reg;
    assign is_empty    = empty;
    assign status      = status_reg;

endmodule

@@ rtl/core/double_ended_queue_reversible_unit.sv @@
// A command accepted at a clock edge passes through the update, memory read and result states;
// its result is then on the outputs with done high, and busy stays high until that cycle has
// ended, so a new command is taken only after the last one has left the result state.
// Reset clears the pointers, count and direction flag at once; the store is not cleared.
// Done is high for a single cycle only, since the receiver cannot stall.
`timescale 1ns / 1ps

module double_ended_queue_reversible_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 command,
    input  logic [VALUE_BITS-1:0]      value,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      front_value,
    output logic [VALUE_BITS-1:0]      back_value,
    output logic [$clog2(DEPTH+1)-1:0] entry_count,
    output logic                       is_empty,
    output logic [1:0]                 status
);

    ctrl_t ctrl;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .command     (command),
        .value       (value),
        .front_value (front_value),
        .back_value  (back_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    assign done = ctrl.respond;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int DEPTH      = 256;
    localparam int VALUE_BITS = 64;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int STALL_LIMIT = 2000;

    // Command codes the block treats as no-ops.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [VALUE_BITS-1:0] front;
        logic [VALUE_BITS-1:0] back;
        logic [CW-1:0]         count;
        logic                  empty;
        status_t               status;
    } deque_view_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [2:0]            command = CMD_PUSH_FRONT;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  busy;
    logic                  done;
    logic [VALUE_BITS-1:0] front_value;
    logic [VALUE_BITS-1:0] back_value;
    logic [CW-1:0]         entry_count;
    logic                  is_empty;
    logic [1:0]            status;

    // Shadow copy of the deque used to work out the expected views.
    logic [VALUE_BITS-1:0] shadow_slots [DEPTH];
    logic [7:0]            shadow_head = '0;
    int                    shadow_count = 0;
    bit                    shadow_rev = 1'b0;

    deque_view_t pending_views [$];
    int  fail_count = 0;
    int  stall_cycles = 0;
    bit  no_idle = 1'b0;
    int  n_push = 0, n_pop = 0, n_rev = 0, n_spare = 0;
    int  n_full_rej = 0, n_empty_rej = 0, peak_count = 0, n_checked = 0;

    double_ended_queue_reversible_unit #(
        .DEPTH(DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .done(done),
        .front_value(front_value),
        .back_value(back_value),
        .entry_count(entry_count),
        .is_empty(is_empty),
        .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic deque_view_t apply_command(logic [2:0] cmd, logic [VALUE_BITS-1:0] val);
        deque_view_t v;
        bit at_low;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        v.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    v.status = ST_PUSH_FULL;
                else
                begin
                    at_low = (cmd == CMD_PUSH_FRONT) != shadow_rev;
                    if (at_low)
                    begin
                        shadow_head = shadow_head - 8'd1;
                        shadow_slots[shadow_head] = val;
                    end
                    else
                        shadow_slots[8'(shadow_head + shadow_count)] = val;
                    shadow_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    v.status = ST_POP_EMPTY;
                else
                begin
                    at_low = (cmd == CMD_POP_FRONT) != shadow_rev;
                    if (at_low)
                        shadow_head = shadow_head + 8'd1;
                    shadow_count--;
                end
            end
            CMD_REVERSE:
            begin
                if (shadow_count > 1)
                    shadow_rev = !shadow_rev;
            end
            default: ;
        endcase
        v.front = '0;
        v.back  = '0;
        if (shadow_count > 0)
        begin
            lo = shadow_slots[shadow_head];
            hi = shadow_slots[8'(shadow_head + shadow_count - 1)];
            v.front = shadow_rev ? hi : lo;
            v.back  = shadow_rev ? lo : hi;
        end
        v.count = CW'(shadow_count);
        v.empty = (shadow_count == 0);
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '1;
        else if (r == 1)
            return '0;
        else
            return {$urandom, $urandom};
    endfunction

    // Drives one command, waits for it to be taken and records the expected view.
    task automatic send_cmd(input logic [2:0] cmd, input logic [VALUE_BITS-1:0] val);
        deque_view_t v;
        int gap;
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        do
            @(posedge clk);
        while (busy);
        v = apply_command(cmd, val);
        pending_views.push_back(v);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: n_push++;
            CMD_POP_FRONT, CMD_POP_BACK:   n_pop++;
            CMD_REVERSE:                   n_rev++;
            default:                       n_spare++;
        endcase
        if (v.status == ST_PUSH_FULL)
            n_full_rej++;
        if (v.status == ST_POP_EMPTY)
            n_empty_rej++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void check_field(string name, logic [VALUE_BITS-1:0] exp_v,
                                        logic [VALUE_BITS-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        deque_view_t e;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                $error("result with no transaction outstanding");
                fail_count++;
            end
            else
            begin
                e = pending_views.pop_front();
                n_checked++;
                check_field("front_value", e.front, front_value);
                check_field("back_value", e.back, back_value);
                check_field("entry_count", VALUE_BITS'(e.count), VALUE_BITS'(entry_count));
                check_field("is_empty", VALUE_BITS'(e.empty), VALUE_BITS'(is_empty));
                check_field("status", VALUE_BITS'(e.status), VALUE_BITS'(status));
            end
        end
    end

    // Ends the run if the block stops taking commands or producing results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_corner_cases();
        no_idle = 1'b0;
        send_cmd(CMD_POP_FRONT, '1);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_SPARE_FIRST, '1);
        send_cmd(3'd6, 64'h0123_4567_89ab_cdef);
        send_cmd(CMD_SPARE_LAST, '1);
        send_cmd(CMD_PUSH_FRONT, '1);
        // Reversing a single entry must leave the direction alone.
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_PUSH_BACK, '0);
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_PUSH_BACK, 64'h5555_5555_5555_5555);
        send_cmd(CMD_PUSH_FRONT, 64'haaaa_aaaa_aaaa_aaaa);
        send_cmd(CMD_PUSH_BACK, 64'h1);
        send_cmd(CMD_REVERSE, '1);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_PUSH_FRONT, 64'h8000_0000_0000_0000);
        send_cmd(CMD_SPARE_LAST, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_FRONT, '0);
    endtask

    task automatic test_full_and_drain();
        int r;
        no_idle = 1'b1;
        while (shadow_count < DEPTH)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                send_cmd(CMD_REVERSE, pick_value());
            else
                send_cmd(r[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
            if (shadow_count == DEPTH / 2)
                no_idle = 1'b0;
        end
        send_cmd(CMD_PUSH_FRONT, pick_value());
        send_cmd(CMD_PUSH_BACK, pick_value());
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_PUSH_FRONT, '1);
        send_cmd(CMD_SPARE_FIRST, '0);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_PUSH_BACK, pick_value());
        send_cmd(CMD_PUSH_BACK, pick_value());
        while (shadow_count > 0)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_cmd(CMD_REVERSE, '0);
            else if (r == 1)
                send_cmd(CMD_PUSH_FRONT, pick_value());
            else
                send_cmd(r[0] ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
        end
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_FRONT, '0);
    endtask

    task automatic test_random_walk(input int n_items);
        int push_bias;
        int r;
        push_bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // New phase every hundred commands: fresh fill bias and idling mode.
            if (i % 100 == 0)
            begin
                push_bias = $urandom_range(5, 95);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                send_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), pick_value());
            else if (r < 18)
                send_cmd(CMD_REVERSE, pick_value());
            else if ($urandom_range(0, 99) < push_bias)
                send_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
            else
                send_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        test_full_and_drain();
        test_random_walk(1300);
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_views.size() != 0)
        begin
            $error("%0d results never arrived", pending_views.size());
            fail_count++;
        end
        $display("Covered %0d pushes, %0d pops, %0d reverses, %0d unused codes; %0d results checked.",
                 n_push, n_pop, n_rev, n_spare, n_checked);
        $display("Rejected %0d pushes when full and %0d pops when empty; peak occupancy %0d.",
                 n_full_rej, n_empty_rej, peak_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
